@@ design/lsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and codes for the latch session controller.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int WINDOW_BITS   = 26;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  // Register indexes
  localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] REG_CONFIRM    = 3'd1;
  localparam logic [2:0] REG_HOLD       = 3'd2;
  localparam logic [2:0] REG_RELOCK     = 3'd3;
  localparam logic [2:0] REG_MAX_ENERG  = 3'd4;
  localparam logic [2:0] REG_REMIND     = 3'd5;
  localparam logic [2:0] REG_WINDOW_MIN = 3'd6;
  localparam logic [2:0] REG_WINDOW_MAX = 3'd7;

  // Item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Debounced edge codes
  localparam logic [1:0] EDGE_QUIET   = 2'd0;
  localparam logic [1:0] EDGE_RETRACT = 2'd1;
  localparam logic [1:0] EDGE_EXTEND  = 2'd2;

  // Published status
  localparam logic [1:0] STATUS_IDLE     = 2'd0;
  localparam logic [1:0] STATUS_UNLOCKED = 2'd1;
  localparam logic [1:0] STATUS_AWAIT    = 2'd2;

  // Session end codes
  localparam logic [1:0] ERR_OK          = 2'd0;
  localparam logic [1:0] ERR_LOCK_FAILED = 2'd1;
  localparam logic [1:0] ERR_NOT_CLOSED  = 2'd2;

  // Start command results
  localparam logic [1:0] START_NONE     = 2'd0;
  localparam logic [1:0] START_ACCEPTED = 2'd1;
  localparam logic [1:0] START_RANGE    = 2'd2;
  localparam logic [1:0] START_BUSY     = 2'd3;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] confirm_timeout_ms;
    logic [15:0] hold_after_retract_ms;
    logic [15:0] relock_timeout_ms;
    logic [15:0] max_energise_ms;
    logic [15:0] remind_period_ms;
    logic [15:0] window_min_s;
    logic [15:0] window_max_s;
  } lsc_cfg_t;

  typedef struct packed {
    logic       coil_on;
    logic [1:0] bin_status;
    logic [1:0] error_code;
    logic [1:0] start_result;
    logic       status_changed;
    logic       remind;
    logic [1:0] latch_edge;
  } lsc_result_t;

endpackage

@@ design/lsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lsc_cfg_regs
// APB register file holding the eight timing and window settings.
// ----------------------------------------------------------------------------
module lsc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsc_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [lsc_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [lsc_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output lsc_pkg::lsc_cfg_t                   cfg
);

  logic       wr_en;
  logic [2:0] reg_index;
  logic [15:0] rd_value;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms           <= 16'd20;
      cfg.confirm_timeout_ms    <= 16'd1500;
      cfg.hold_after_retract_ms <= 16'd300;
      cfg.relock_timeout_ms     <= 16'd2000;
      cfg.max_energise_ms       <= 16'd5000;
      cfg.remind_period_ms      <= 16'd10000;
      cfg.window_min_s          <= 16'd5;
      cfg.window_max_s          <= 16'd120;
    end else if (wr_en) begin
      case (reg_index)
        lsc_pkg::REG_DEBOUNCE:   cfg.debounce_ms           <= pwdata[15:0];
        lsc_pkg::REG_CONFIRM:    cfg.confirm_timeout_ms    <= pwdata[15:0];
        lsc_pkg::REG_HOLD:       cfg.hold_after_retract_ms <= pwdata[15:0];
        lsc_pkg::REG_RELOCK:     cfg.relock_timeout_ms     <= pwdata[15:0];
        lsc_pkg::REG_MAX_ENERG:  cfg.max_energise_ms       <= pwdata[15:0];
        lsc_pkg::REG_REMIND:     cfg.remind_period_ms      <= pwdata[15:0];
        lsc_pkg::REG_WINDOW_MIN: cfg.window_min_s          <= pwdata[15:0];
        lsc_pkg::REG_WINDOW_MAX: cfg.window_max_s          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      lsc_pkg::REG_DEBOUNCE:   rd_value = cfg.debounce_ms;
      lsc_pkg::REG_CONFIRM:    rd_value = cfg.confirm_timeout_ms;
      lsc_pkg::REG_HOLD:       rd_value = cfg.hold_after_retract_ms;
      lsc_pkg::REG_RELOCK:     rd_value = cfg.relock_timeout_ms;
      lsc_pkg::REG_MAX_ENERG:  rd_value = cfg.max_energise_ms;
      lsc_pkg::REG_REMIND:     rd_value = cfg.remind_period_ms;
      lsc_pkg::REG_WINDOW_MIN: rd_value = cfg.window_min_s;
      lsc_pkg::REG_WINDOW_MAX: rd_value = cfg.window_max_s;
      default:                 rd_value = 16'd0;
    endcase
  end

  assign prdata = {{(lsc_pkg::CFG_DATA_BITS-16){1'b0}}, rd_value};

endmodule

@@ design/lsc_debounce.sv @@
// ----------------------------------------------------------------------------
// lsc_debounce
// Contact debouncer: accepts a new level only after the hold time and
// reports retract or extend edges.
// ----------------------------------------------------------------------------
module lsc_debounce #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample,
  input  logic                 raw,
  input  logic [TIME_BITS-1:0] now_inc,
  input  logic [15:0]          debounce_ms,
  output logic [1:0]           latch_edge
);

  logic                 level;
  logic                 level_known;
  logic [TIME_BITS-1:0] changed_time;
  logic                 level_next;
  logic                 level_known_next;
  logic [TIME_BITS-1:0] changed_time_next;
  logic [TIME_BITS-1:0] since_change;

  assign since_change = now_inc - changed_time;

  always_comb begin
    level_next        = level;
    level_known_next  = 1'b1;
    changed_time_next = changed_time;
    latch_edge        = lsc_pkg::EDGE_QUIET;
    if (!level_known) begin
      // first sample after reset: adopt the level silently
      level_next        = raw;
      changed_time_next = now_inc;
    end else if (raw != level && since_change >= TIME_BITS'(debounce_ms)) begin
      level_next        = raw;
      changed_time_next = now_inc;
      latch_edge        = raw ? lsc_pkg::EDGE_RETRACT : lsc_pkg::EDGE_EXTEND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= 1'b0;
      level_known  <= 1'b0;
      changed_time <= '0;
    end else if (sample) begin
      level        <= level_next;
      level_known  <= level_known_next;
      changed_time <= changed_time_next;
    end
  end

endmodule

@@ design/lsc_session.sv @@
// ----------------------------------------------------------------------------
// lsc_session
// Unlock session sequencer: start checks, coil control, phase timeouts,
// reminders and end codes.
// ----------------------------------------------------------------------------
module lsc_session #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  kind,
  input  logic [15:0]           window_seconds,
  input  logic [1:0]            latch_edge,
  input  logic [TIME_BITS-1:0]  now_ms,
  input  logic [TIME_BITS-1:0]  now_inc,
  input  lsc_pkg::lsc_cfg_t     cfg,
  output lsc_pkg::lsc_result_t  result
);

  localparam int CMP_BITS = (TIME_BITS > lsc_pkg::WINDOW_BITS) ? TIME_BITS
                                                               : lsc_pkg::WINDOW_BITS;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PULSING,
    PH_CLEARING,
    PH_AWAIT,
    PH_RELOCK
  } phase_t;

  phase_t                          phase, phase_next;
  logic [1:0]                      status, status_next;
  logic [1:0]                      error, error_next;
  logic                            coil, coil_next;
  logic [TIME_BITS-1:0]            energised_time, energised_time_next;
  logic [TIME_BITS-1:0]            phase_time, phase_time_next;
  logic [TIME_BITS-1:0]            remind_time, remind_time_next;
  logic [lsc_pkg::WINDOW_BITS-1:0] window_ms, window_ms_next;

  logic [TIME_BITS-1:0] since_energised;
  logic [TIME_BITS-1:0] since_phase;
  logic [TIME_BITS-1:0] since_remind;
  logic                 end_req;
  logic [1:0]           end_code;
  logic [1:0]           start_result;
  logic                 changed;
  logic                 remind;

  assign since_energised = now_inc - energised_time;
  assign since_phase     = now_inc - phase_time;
  assign since_remind    = now_inc - remind_time;

  always_comb begin
    phase_next          = phase;
    status_next         = status;
    error_next          = error;
    coil_next           = coil;
    energised_time_next = energised_time;
    phase_time_next     = phase_time;
    remind_time_next    = remind_time;
    window_ms_next      = window_ms;
    end_req             = 1'b0;
    end_code            = lsc_pkg::ERR_OK;
    start_result        = lsc_pkg::START_NONE;
    changed             = 1'b0;
    remind              = 1'b0;

    if (kind == lsc_pkg::KIND_TICK) begin
      if (phase != PH_IDLE) begin
        if (coil && since_energised >= TIME_BITS'(cfg.max_energise_ms)) begin
          end_req  = 1'b1;
          end_code = lsc_pkg::ERR_LOCK_FAILED;
        end else begin
          case (phase)
            PH_PULSING: begin
              if (latch_edge == lsc_pkg::EDGE_RETRACT) begin
                phase_next      = PH_CLEARING;
                phase_time_next = now_inc;
              end else if (since_energised >= TIME_BITS'(cfg.confirm_timeout_ms)) begin
                end_req  = 1'b1;
                end_code = lsc_pkg::ERR_LOCK_FAILED;
              end
            end
            PH_CLEARING: begin
              if (since_phase >= TIME_BITS'(cfg.hold_after_retract_ms)) begin
                coil_next        = 1'b0;
                phase_next       = PH_AWAIT;
                phase_time_next  = now_inc;
                remind_time_next = now_inc;
                status_next      = lsc_pkg::STATUS_AWAIT;
                changed          = 1'b1;
              end
            end
            PH_AWAIT: begin
              if (latch_edge == lsc_pkg::EDGE_RETRACT) begin
                phase_next      = PH_RELOCK;
                phase_time_next = now_inc;
              end else begin
                if (since_remind >= TIME_BITS'(cfg.remind_period_ms)) begin
                  remind_time_next = now_inc;
                  remind           = 1'b1;
                end
                // reminder and window expiry may land on the same tick
                if (CMP_BITS'(since_phase) >= CMP_BITS'(window_ms)) begin
                  end_req  = 1'b1;
                  end_code = lsc_pkg::ERR_NOT_CLOSED;
                end
              end
            end
            PH_RELOCK: begin
              if (latch_edge == lsc_pkg::EDGE_EXTEND) begin
                end_req  = 1'b1;
                end_code = lsc_pkg::ERR_OK;
              end else if (since_phase >= TIME_BITS'(cfg.relock_timeout_ms)) begin
                end_req  = 1'b1;
                end_code = lsc_pkg::ERR_LOCK_FAILED;
              end
            end
            default: ;
          endcase
        end
      end
    end else if (window_seconds < cfg.window_min_s || window_seconds > cfg.window_max_s) begin
      start_result = lsc_pkg::START_RANGE;
    end else if (status != lsc_pkg::STATUS_IDLE) begin
      start_result = lsc_pkg::START_BUSY;
    end else begin
      start_result        = lsc_pkg::START_ACCEPTED;
      window_ms_next      = lsc_pkg::WINDOW_BITS'(window_seconds)
                          * lsc_pkg::WINDOW_BITS'(lsc_pkg::MS_PER_S);
      energised_time_next = now_ms;
      phase_time_next     = now_ms;
      remind_time_next    = '0;
      phase_next          = PH_PULSING;
      status_next         = lsc_pkg::STATUS_UNLOCKED;
      error_next          = lsc_pkg::ERR_OK;
      coil_next           = 1'b1;
      changed             = 1'b1;
    end

    if (end_req) begin
      coil_next   = 1'b0;
      phase_next  = PH_IDLE;
      status_next = lsc_pkg::STATUS_IDLE;
      error_next  = end_code;
      changed     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      status         <= lsc_pkg::STATUS_IDLE;
      error          <= lsc_pkg::ERR_OK;
      coil           <= 1'b0;
      energised_time <= '0;
      phase_time     <= '0;
      remind_time    <= '0;
      window_ms      <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      status         <= status_next;
      error          <= error_next;
      coil           <= coil_next;
      energised_time <= energised_time_next;
      phase_time     <= phase_time_next;
      remind_time    <= remind_time_next;
      window_ms      <= window_ms_next;
    end
  end

  always_comb begin
    result.coil_on        = coil_next;
    result.bin_status     = status_next;
    result.error_code     = error_next;
    result.start_result   = start_result;
    result.status_changed = changed;
    result.remind         = remind;
    result.latch_edge     = latch_edge;
  end

endmodule

@@ design/latch_session_controller_unit.sv @@
// ----------------------------------------------------------------------------
// latch_session_controller_unit
// Pulsed solenoid latch controller: tick and start beats in, one result
// beat out per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | in_valid / in_stall | kind, contact_retracted,
//          |           |                     | window_seconds
//  out     | output    | out_valid/out_stall | coil_on, bin_status, error_code,
//          |           |                     | start_result, status_changed,
//          |           |                     | remind, latch_edge
//  cfg     | APB slave | psel/penable/pready | paddr, pwdata, prdata
//
//  One item per cycle sustained while out_stall is low; a beat accepted
//  into the input register moves on to the result register once that
//  register is free, and its result is offered from there.
//  The session and debounce update is one pass of logic between the two.
//  Reset (rst, synchronous) idles the session and restores register defaults.
//  out_stall holds the result register; the input register takes a beat
//  while it is empty or its item can move on, so at most two items wait.
// ----------------------------------------------------------------------------
module latch_session_controller_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // item input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic                               contact_retracted,
  input  logic [15:0]                        window_seconds,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               coil_on,
  output logic [1:0]                         bin_status,
  output logic [1:0]                         error_code,
  output logic [1:0]                         start_result,
  output logic                               status_changed,
  output logic                               remind,
  output logic [1:0]                         latch_edge,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lsc_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [lsc_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [lsc_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  lsc_pkg::lsc_cfg_t    cfg;
  lsc_pkg::lsc_result_t result;
  lsc_pkg::lsc_result_t out_q;

  logic                 in_q_valid;
  logic                 in_q_kind;
  logic                 in_q_raw;
  logic [15:0]          in_q_window;
  logic                 advance;
  logic                 fire;
  logic                 tick_fire;
  logic [TIME_BITS-1:0] now_ms;
  logic [TIME_BITS-1:0] now_inc;
  logic [1:0]           edge_code;

  assign advance   = !out_valid || !out_stall;
  assign fire      = in_q_valid && advance;
  assign tick_fire = fire && (in_q_kind == lsc_pkg::KIND_TICK);
  assign in_stall  = in_q_valid && !advance;
  assign now_inc   = now_ms + TIME_BITS'(1);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q_kind   <= kind;
      in_q_raw    <= contact_retracted;
      in_q_window <= window_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
    end else if (tick_fire) begin
      now_ms <= now_inc;
    end
  end

  lsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsc_debounce #(
    .TIME_BITS (TIME_BITS)
  ) u_debounce (
    .clk         (clk),
    .rst         (rst),
    .sample      (tick_fire),
    .raw         (in_q_raw),
    .now_inc     (now_inc),
    .debounce_ms (cfg.debounce_ms),
    .latch_edge  (edge_code)
  );

  lsc_session #(
    .TIME_BITS (TIME_BITS)
  ) u_session (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .kind           (in_q_kind),
    .window_seconds (in_q_window),
    .latch_edge     ((in_q_kind == lsc_pkg::KIND_TICK) ? edge_code : lsc_pkg::EDGE_QUIET),
    .now_ms         (now_ms),
    .now_inc        (now_inc),
    .cfg            (cfg),
    .result         (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign coil_on        = out_q.coil_on;
  assign bin_status     = out_q.bin_status;
  assign error_code     = out_q.error_code;
  assign start_result   = out_q.start_result;
  assign status_changed = out_q.status_changed;
  assign remind         = out_q.remind;
  assign latch_edge     = out_q.latch_edge;

endmodule

@@ design/lsc_checker.sv @@
// ----------------------------------------------------------------------------
// lsc_port_checks
// Port-level checks on the latch session controller result stream.
// ----------------------------------------------------------------------------
module lsc_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       coil_on,
  input logic [1:0] bin_status,
  input logic [1:0] error_code,
  input logic [1:0] start_result,
  input logic       status_changed,
  input logic       remind,
  input logic [1:0] latch_edge
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(coil_on) && $stable(bin_status)
      && $stable(error_code) && $stable(start_result) && $stable(status_changed)
      && $stable(remind) && $stable(latch_edge))
    else $error("result beat changed while stalled");

  // an accepted start energises the coil and publishes a clean unlocked status
  a_start_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_result == lsc_pkg::START_ACCEPTED |->
      coil_on && bin_status == lsc_pkg::STATUS_UNLOCKED
      && error_code == lsc_pkg::ERR_OK && status_changed)
    else $error("accepted start without coil on and unlocked status");

  // start beats never carry tick-only outputs
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_result != lsc_pkg::START_NONE |->
      latch_edge == lsc_pkg::EDGE_QUIET && !remind)
    else $error("start beat reported an edge or reminder");

  // coil is off whenever the lid close is awaited or a reminder fires
  a_await_coil_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (bin_status == lsc_pkg::STATUS_AWAIT || remind) |-> !coil_on)
    else $error("coil on while awaiting lid close");

endmodule

bind latch_session_controller_unit lsc_port_checks u_lsc_port_checks (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .coil_on        (coil_on),
  .bin_status     (bin_status),
  .error_code     (error_code),
  .start_result   (start_result),
  .status_changed (status_changed),
  .remind         (remind),
  .latch_edge     (latch_edge)
);
